// ===== rtl/core/gfb_pkg.sv =====
// ----------------------------------------------------------------------------
// gfb_pkg
// shared types, constants and helpers of the goertzel filter bank
// ----------------------------------------------------------------------------
`default_nettype none

package gfb_pkg;

	localparam int NUM_KEYS  = 64;
	localparam int KEY_W     = 6;
	localparam int CNT_W     = 7;
	localparam int ACC_W     = 48;
	localparam int COEF_W    = 19;
	localparam int SAMP_W    = 16;
	localparam int MAX_BLOCK = 4096;
	localparam int BLK_W     = 13;
	localparam int MAG_W     = 32;

	// sequential multiplier: a in 32-bit digits, b in 16-bit digits
	localparam int MA_W   = 96;
	localparam int MB_W   = 48;
	localparam int MP_W   = MA_W + MB_W;
	localparam int MA_DIG = 32;
	localparam int MB_DIG = 16;
	localparam int MA_N   = MA_W / MA_DIG;
	localparam int MB_N   = MB_W / MB_DIG;
	localparam int SH_W   = 7;

	localparam int SAT_W  = 68;
	localparam int Q_W    = 120;
	localparam int ROOT_W = Q_W / 2;
	localparam int DIVD_W = ROOT_W - 8;
	localparam int ITER_W = 6;

	localparam logic ACT_COEFF  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_FIRST_KEY = 2'd0;
	localparam cfg_idx_t CFG_KEY_COUNT = 2'd1;
	localparam cfg_idx_t CFG_BLOCK_LEN = 2'd2;

	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		acc_t  s1;
		acc_t  s2;
		coef_t c;
	} cell_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_UPD_WT,
		ST_UPD_U,
		ST_UPD_S,
		ST_MAG,
		ST_MAG_GO,
		ST_MAG_WT,
		ST_MAG_P,
		ST_MAG_Q1,
		ST_MAG_Q2,
		ST_MAG_RS,
		ST_MAG_RT,
		ST_MAG_OUT
	} gfb_state_t;

	typedef enum logic [1:0] {
		OP_S1SQ,
		OP_S2SQ,
		OP_S1S2,
		OP_CX
	} mag_op_t;

	typedef enum logic [1:0] {
		RP_IDLE,
		RP_SQRT,
		RP_DIV
	} root_phase_t;

	function automatic acc_t sat_acc(input logic signed [SAT_W-1:0] v);
		logic [SAT_W-ACC_W:0] top;
		top = v[SAT_W-1:ACC_W-1];
		if (&top || ~|top)
			return v[ACC_W-1:0];
		else if (v[SAT_W-1])
			return {1'b1, {(ACC_W-1){1'b0}}};
		else
			return {1'b0, {(ACC_W-1){1'b1}}};
	endfunction

	function automatic logic [ACC_W-1:0] abs_acc(input acc_t v);
		logic [ACC_W-1:0] u;
		u = v;
		return v[ACC_W-1] ? (~u + 1'b1) : u;
	endfunction

	function automatic logic [COEF_W-1:0] abs_coef(input coef_t v);
		logic [COEF_W-1:0] u;
		u = v;
		return v[COEF_W-1] ? (~u + 1'b1) : u;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/goertzel_filter_bank_core.sv =====
// ----------------------------------------------------------------------------
// goertzel_filter_bank_core
// a sample rotates the 64-cell key ring once: idle keys shift straight past
// and each active key waits on the shared multiplier
// the last sample of a block adds a second rotation for the magnitudes, each
// active key using the multiplier and then the root/divide unit (skipped when
// the magnitude is zero), plus result stalls
// one word in flight at a time; coefficient words are taken only while idle and go straight into their cell
// arst_n clears the running pairs, the counters and the registers to defaults
// ----------------------------------------------------------------------------
`default_nettype none

module goertzel_filter_bank_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [47:0]             s_tdata,   // coeff_key, coeff_value, sample_value
	input  logic                    s_tuser,   // action
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [39:0]             m_tdata,   // result_key, magnitude
	output logic                    m_tlast,   // last_of_block
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  gfb_pkg::cfg_idx_t       cfg_index,
	input  logic [12:0]             cfg_data
);
	import gfb_pkg::*;

	logic [KEY_W-1:0] first_q;
	logic [CNT_W-1:0] count_q;
	logic [BLK_W-1:0] blen_q;

	gfb_state_t       state_q;
	gfb_state_t       state_d;
	logic [KEY_W-1:0] k_q;
	logic [BLK_W-1:0] cnt_q;
	logic             m_tvalid_q;

	logic signed [SAMP_W-1:0] x_q;
	logic                     neg_q;
	mag_op_t                  op_q;
	acc_t                     t_q;
	acc_t                     u_q;
	logic [MA_W:0]            e_q;
	logic [MA_W-1:0]          m1_q;
	logic signed [Q_W-1:0]    p_q;
	logic [Q_W-1:0]           q_q;
	logic [MAG_W-1:0]         mag_q;
	logic [KEY_W-1:0]         out_key_q;
	logic [MAG_W-1:0]         out_mag_q;
	logic                     out_last_q;

	cell_word_t cell_q [NUM_KEYS];
	cell_word_t head;
	cell_word_t wb;

	logic             in_acc;
	logic             coef_wr;
	logic [KEY_W-1:0] coef_key;
	coef_t            coef_val;
	logic [KEY_W+1:0] key_end;
	logic [KEY_W:0]   end_c;
	logic             active;
	logic             last_key;
	logic             wrap;
	logic [BLK_W-1:0] n_eff;
	logic [BLK_W-1:0] cnt_inc;
	logic             blk_end;
	logic             upd_pass;

	logic             mul_start;
	logic             mul_done;
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [MP_W-1:0]  mul_prod;
	logic             root_start;
	logic             root_done;
	logic [MAG_W-1:0] root_mag;
	logic             advance;
	logic             clear_all;
	logic             out_load;
	logic             p_pos;

	logic signed [SAT_W-1:0] prod_s;
	logic signed [SAT_W-1:0] t_ext;
	logic signed [SAT_W-1:0] u_sum;
	logic signed [SAT_W-1:0] s_dif;
	logic [Q_W-1:0]          e16;
	logic [Q_W-1:0]          m2;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			count_q <= CNT_W'(NUM_KEYS);
			blen_q  <= BLK_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIRST_KEY: first_q <= cfg_data[KEY_W-1:0];
				CFG_KEY_COUNT: count_q <= cfg_data[CNT_W-1:0];
				CFG_BLOCK_LEN: blen_q  <= cfg_data[BLK_W-1:0];
				default: ;
			endcase
		end
	end

	// input word
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign coef_wr  = in_acc && (s_tuser == ACT_COEFF);
	assign coef_key = s_tdata[5:0];
	assign coef_val = s_tdata[24:6];

	// key ring
	assign head = cell_q[0];

	for (genvar j = 0; j < NUM_KEYS; j++) begin : g_cell
		cell_word_t d_in;
		if (j == NUM_KEYS - 1) begin : g_tail
			assign d_in = wb;
		end else begin : g_link
			assign d_in = cell_q[j+1];
		end
		gfb_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (advance),
			.clear    (clear_all),
			.wr_en    (coef_wr && (coef_key == KEY_W'(j))),
			.wr_coeff (coef_val),
			.d        (d_in),
			.q        (cell_q[j])
		);
	end

	// key range and block length
	assign key_end  = {2'b00, first_q} + {1'b0, count_q};
	assign end_c    = (key_end > (KEY_W+2)'(NUM_KEYS)) ? (KEY_W+1)'(NUM_KEYS) :
	                  key_end[KEY_W:0];
	assign active   = (k_q >= first_q) && ({1'b0, k_q} < end_c);
	assign last_key = (({1'b0, k_q} + 1'b1) == end_c);
	assign wrap     = (k_q == KEY_W'(NUM_KEYS - 1));
	assign n_eff    = (blen_q == '0) ? BLK_W'(1) :
	                  (blen_q > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : blen_q;
	assign cnt_inc  = cnt_q + 1'b1;
	assign blk_end  = (cnt_inc >= n_eff);
	assign upd_pass = (state_q == ST_UPD) || (state_q == ST_UPD_S);

	// resonator update arithmetic
	assign prod_s = neg_q ? -{1'b0, mul_prod[SAT_W-2:0]} : {1'b0, mul_prod[SAT_W-2:0]};
	assign t_ext  = {{16{prod_s[SAT_W-1]}}, prod_s[SAT_W-1:16]};
	assign u_sum  = {{(SAT_W-SAMP_W){x_q[SAMP_W-1]}}, x_q} +
	                {{(SAT_W-ACC_W){t_q[ACC_W-1]}}, t_q};
	assign s_dif  = {{(SAT_W-ACC_W){u_q[ACC_W-1]}}, u_q} -
	                {{(SAT_W-ACC_W){head.s2[ACC_W-1]}}, head.s2};

	always_comb begin
		wb = head;
		if (state_q == ST_UPD_S) begin
			wb.s1 = sat_acc(s_dif);
			wb.s2 = head.s1;
		end
	end

	// magnitude arithmetic
	assign e16   = {{(Q_W-MA_W-17){1'b0}}, e_q, 16'd0};
	assign m2    = mul_prod[Q_W-1:0];
	assign p_pos = !p_q[Q_W-1] && (p_q != '0);

	always_comb begin
		mul_a = {{(MA_W-ACC_W){1'b0}}, abs_acc(head.s1)};
		mul_b = {{(MB_W-COEF_W){1'b0}}, abs_coef(head.c)};
		if (state_q != ST_UPD) begin
			case (op_q)
				OP_S1SQ: begin
					mul_a = {{(MA_W-ACC_W){1'b0}}, abs_acc(head.s1)};
					mul_b = abs_acc(head.s1);
				end
				OP_S2SQ: begin
					mul_a = {{(MA_W-ACC_W){1'b0}}, abs_acc(head.s2)};
					mul_b = abs_acc(head.s2);
				end
				OP_S1S2: begin
					mul_a = {{(MA_W-ACC_W){1'b0}}, abs_acc(head.s1)};
					mul_b = abs_acc(head.s2);
				end
				default: begin
					mul_a = m1_q;
					mul_b = {{(MB_W-COEF_W){1'b0}}, abs_coef(head.c)};
				end
			endcase
		end
	end

	gfb_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	gfb_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.q      (q_q),
		.n      (n_eff),
		.done   (root_done),
		.mag    (root_mag)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		root_start = 1'b0;
		advance    = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (s_tuser == ACT_SAMPLE)) state_d = ST_UPD;
			end
			ST_UPD: begin
				if (active) begin
					mul_start = 1'b1;
					state_d   = ST_UPD_WT;
				end else begin
					advance = 1'b1;
					if (wrap) state_d = blk_end ? ST_MAG : ST_IDLE;
				end
			end
			ST_UPD_WT: begin
				if (mul_done) state_d = ST_UPD_U;
			end
			ST_UPD_U: state_d = ST_UPD_S;
			ST_UPD_S: begin
				advance = 1'b1;
				state_d = wrap ? (blk_end ? ST_MAG : ST_IDLE) : ST_UPD;
			end
			ST_MAG: begin
				if (active) begin
					state_d = ST_MAG_GO;
				end else begin
					advance = 1'b1;
					if (wrap) state_d = ST_IDLE;
				end
			end
			ST_MAG_GO: begin
				mul_start = 1'b1;
				state_d   = ST_MAG_WT;
			end
			ST_MAG_WT: begin
				if (mul_done) state_d = (op_q == OP_CX) ? ST_MAG_P : ST_MAG_GO;
			end
			ST_MAG_P:  state_d = ST_MAG_Q1;
			ST_MAG_Q1: state_d = p_pos ? ST_MAG_Q2 : ST_MAG_OUT;
			ST_MAG_Q2: state_d = ST_MAG_RS;
			ST_MAG_RS: begin
				root_start = 1'b1;
				state_d    = ST_MAG_RT;
			end
			ST_MAG_RT: begin
				if (root_done) state_d = ST_MAG_OUT;
			end
			ST_MAG_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					advance  = 1'b1;
					state_d  = wrap ? ST_IDLE : ST_MAG;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign clear_all = advance && wrap && !upd_pass;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (advance) k_q <= k_q + 1'b1;
			if (advance && wrap) begin
				cnt_q <= upd_pass ? cnt_inc : '0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) x_q <= s_tdata[40:25];
			end
			ST_UPD: begin
				neg_q <= head.c[COEF_W-1] ^ head.s1[ACC_W-1];
			end
			ST_UPD_WT: begin
				if (mul_done) t_q <= sat_acc(t_ext);
			end
			ST_UPD_U: begin
				u_q <= sat_acc(u_sum);
			end
			ST_MAG: begin
				neg_q <= head.c[COEF_W-1] ^ head.s1[ACC_W-1] ^ head.s2[ACC_W-1];
				op_q  <= OP_S1SQ;
			end
			ST_MAG_WT: begin
				if (mul_done) begin
					case (op_q)
						OP_S1SQ: e_q  <= {1'b0, mul_prod[MA_W-1:0]};
						OP_S2SQ: e_q  <= e_q + {1'b0, mul_prod[MA_W-1:0]};
						OP_S1S2: m1_q <= mul_prod[MA_W-1:0];
						default: ;
					endcase
					if (op_q != OP_CX) op_q <= mag_op_t'(op_q + 1'b1);
				end
			end
			ST_MAG_P: begin
				p_q <= neg_q ? (e16 + m2) : (e16 - m2);
			end
			ST_MAG_Q1: begin
				q_q   <= p_q + {p_q[Q_W-4:0], 3'd0};
				mag_q <= '0;
			end
			ST_MAG_Q2: begin
				q_q <= q_q + {p_q[Q_W-5:0], 4'd0};
			end
			ST_MAG_RT: begin
				if (root_done) mag_q <= root_mag;
			end
			default: ;
		endcase
		if (out_load) begin
			out_key_q  <= k_q;
			out_mag_q  <= mag_q;
			out_last_q <= last_key;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_mag_q, out_key_q};
	assign m_tlast  = out_last_q;

	// checks
	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_UPD_WT || state_q == ST_MAG_WT))
		else $error("multiplier finished outside a wait state");

	a_root_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == ST_MAG_RT))
		else $error("root unit finished outside its wait state");

	a_ring_home: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (k_q == '0))
		else $error("key ring not back in place when ready");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		clear_all |=> (state_q == ST_IDLE && cnt_q == '0))
		else $error("block end did not return to idle");

endmodule

`default_nettype wire

// ===== rtl/core/gfb_cell.sv =====
// ----------------------------------------------------------------------------
// gfb_cell
// one ring cell: running pair and coefficient of one key
// ----------------------------------------------------------------------------
`default_nettype none

module gfb_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  logic                      clear,
	input  logic                      wr_en,
	input  gfb_pkg::coef_t            wr_coeff,
	input  gfb_pkg::cell_word_t       d,
	output gfb_pkg::cell_word_t       q
);
	import gfb_pkg::*;

	acc_t  s1_q;
	acc_t  s2_q;
	coef_t c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
		end else if (clear) begin
			s1_q <= '0;
			s2_q <= '0;
		end else if (shift) begin
			s1_q <= d.s1;
			s2_q <= d.s2;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			c_q <= wr_coeff;
		end else if (shift) begin
			c_q <= d.c;
		end
	end

	assign q = '{s1: s1_q, s2: s2_q, c: c_q};

endmodule

`default_nettype wire

// ===== rtl/core/gfb_mul.sv =====
// ----------------------------------------------------------------------------
// gfb_mul
// unsigned digit-serial multiplier, one 32x16 partial product per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module gfb_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gfb_pkg::MA_W-1:0]    a,
	input  logic [gfb_pkg::MB_W-1:0]    b,
	output logic                        done,
	output logic [gfb_pkg::MP_W-1:0]    prod
);
	import gfb_pkg::*;

	logic [MA_W-1:0] a_q;
	logic [MB_W-1:0] b_q;
	logic [MP_W-1:0] acc_q;
	logic [1:0]      i_q;
	logic [1:0]      j_q;
	logic            busy_q;
	logic            done_q;

	logic [MA_DIG+MB_DIG-1:0] pp;
	logic [SH_W-1:0]          sh;
	logic                     last_i;
	logic                     last_j;

	assign pp     = a_q[{i_q, 5'd0} +: MA_DIG] * b_q[{j_q, 4'd0} +: MB_DIG];
	assign sh     = {i_q, 5'd0} + {1'b0, j_q, 4'd0};
	assign last_i = (i_q == 2'(MA_N - 1));
	assign last_j = (j_q == 2'(MB_N - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
			end else if (busy_q) begin
				if (last_j) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
				if (last_i && last_j) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + ({{(MP_W-MA_DIG-MB_DIG){1'b0}}, pp} << sh);
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/gfb_root.sv =====
// ----------------------------------------------------------------------------
// gfb_root
// bit-serial square root followed by restoring division by the block length
// ----------------------------------------------------------------------------
`default_nettype none

module gfb_root (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gfb_pkg::Q_W-1:0]     q,
	input  logic [gfb_pkg::BLK_W-1:0]   n,
	output logic                        done,
	output logic [gfb_pkg::MAG_W-1:0]   mag
);
	import gfb_pkg::*;

	root_phase_t phase_q;
	root_phase_t phase_d;
	logic [ITER_W-1:0] it_q;
	logic              done_q;

	logic [Q_W-1:0]      qs_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [DIVD_W-1:0]   dq_q;
	logic [BLK_W-1:0]    drem_q;
	logic [BLK_W-1:0]    n_q;

	logic [ROOT_W+3:0]   rem_t;
	logic [ROOT_W+3:0]   trial;
	logic                take;
	logic [ROOT_W+3:0]   rem_sub;
	logic [ROOT_W-1:0]   root_next;
	logic [BLK_W:0]      r_t;
	logic                ge;
	logic [BLK_W:0]      r_sub;
	logic                sqrt_last;
	logic                div_last;

	assign rem_t     = {rem_q, qs_q[Q_W-1 -: 2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign take      = (rem_t >= trial);
	assign rem_sub   = rem_t - trial;
	assign root_next = {root_q[ROOT_W-2:0], take};
	assign r_t       = {drem_q, dq_q[DIVD_W-1]};
	assign ge        = (r_t >= {1'b0, n_q});
	assign r_sub     = r_t - {1'b0, n_q};
	assign sqrt_last = (it_q == ITER_W'(ROOT_W - 1));
	assign div_last  = (it_q == ITER_W'(DIVD_W - 1));

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			RP_IDLE: if (start) phase_d = RP_SQRT;
			RP_SQRT: if (sqrt_last) phase_d = RP_DIV;
			RP_DIV:  if (div_last) phase_d = RP_IDLE;
			default: phase_d = RP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RP_IDLE;
			it_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == RP_DIV) && div_last;
			if (phase_q != phase_d) begin
				it_q <= '0;
			end else if (phase_q != RP_IDLE) begin
				it_q <= it_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			RP_IDLE: begin
				if (start) begin
					qs_q   <= q;
					rem_q  <= '0;
					root_q <= '0;
					n_q    <= n;
				end
			end
			RP_SQRT: begin
				qs_q   <= {qs_q[Q_W-3:0], 2'b00};
				rem_q  <= take ? rem_sub[ROOT_W+1:0] : rem_t[ROOT_W+1:0];
				root_q <= root_next;
				if (sqrt_last) begin
					dq_q   <= root_next[ROOT_W-1:ROOT_W-DIVD_W];
					drem_q <= '0;
				end
			end
			RP_DIV: begin
				drem_q <= ge ? r_sub[BLK_W-1:0] : r_t[BLK_W-1:0];
				dq_q   <= {dq_q[DIVD_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign mag  = (|dq_q[DIVD_W-1:MAG_W]) ? {MAG_W{1'b1}} : dq_q[MAG_W-1:0];

endmodule

`default_nettype wire

// ===== tb/sv/goertzel_filter_bank_checker.sv =====
// ----------------------------------------------------------------------------
// goertzel_filter_bank_checker
// watches the coefficient/sample, result and register channels, keeps its own
// copy of the resonator bank and compares every result word with the oldest
// predicted key, magnitude and last flag
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module goertzel_filter_bank_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [47:0]         s_tdata,
	input  logic                s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [39:0]         m_tdata,
	input  logic                m_tlast,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  gfb_pkg::cfg_idx_t   cfg_index,
	input  logic [12:0]         cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import gfb_pkg::*;

	typedef struct {
		logic [5:0]  key;
		logic [31:0] mag;
		logic        last;
	} tone_t;

	tone_t       tones_due[$];
	coef_t       coef_tab[NUM_KEYS];
	acc_t        recent[NUM_KEYS];
	acc_t        older[NUM_KEYS];
	int          sample_cnt;
	logic [5:0]  first_key;
	logic [6:0]  key_count;
	logic [12:0] block_len;

	assign pending = tones_due.size();

	function automatic acc_t clamp_acc(input logic signed [95:0] v);
		logic signed [95:0] top;
		top = (96'sd1 <<< 47) - 96'sd1;
		if (v > top)
			return top[47:0];
		if (v < -top - 96'sd1)
			return {1'b1, 47'd0};
		return v[47:0];
	endfunction

	function automatic acc_t resonate(input coef_t c, input acc_t s1, input acc_t s2,
			input logic signed [15:0] x);
		logic signed [95:0] cw, s1w, s2w, xw, t;
		cw = c;
		s1w = s1;
		s2w = s2;
		xw = x;
		t = clamp_acc((cw * s1w) >>> 16);
		t = clamp_acc(xw + t);
		return clamp_acc(t - s2w);
	endfunction

	function automatic logic [31:0] tone_level(input coef_t c, input acc_t s1, input acc_t s2,
			input int n);
		logic signed [159:0] a, b, cc, p;
		logic [159:0] q, t, sq;
		longint unsigned lo, hi, mid;
		a = s1;
		b = s2;
		cc = c;
		p = (a * a + b * b) * 160'sd65536 - cc * a * b;
		if (p <= 0)
			return 32'd0;
		q = p * 25;
		lo = 0;
		hi = 64'hFFFF_FFFF;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			t = 160'(n) * 160'(mid);
			sq = t * t * 160'd65536;
			if (sq <= q)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo[31:0];
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic take_sample(input logic signed [15:0] x);
		int stop, n;
		tone_t tn;
		stop = int'(first_key) + int'(key_count);
		if (stop > NUM_KEYS)
			stop = NUM_KEYS;
		for (int k = first_key; k < stop; k++) begin
			acc_t s;
			s = resonate(coef_tab[k], recent[k], older[k], x);
			older[k] = recent[k];
			recent[k] = s;
		end
		sample_cnt++;
		n = (block_len == 0) ? 1 : (block_len > MAX_BLOCK) ? MAX_BLOCK : int'(block_len);
		if (sample_cnt >= n) begin
			for (int k = first_key; k < stop; k++) begin
				tn.key = k[5:0];
				tn.mag = tone_level(coef_tab[k], recent[k], older[k], n);
				tn.last = (k + 1 == stop);
				tones_due.push_back(tn);
			end
			for (int k = 0; k < NUM_KEYS; k++) begin
				recent[k] = '0;
				older[k] = '0;
			end
			sample_cnt = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tone_t tn;
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				coef_tab[k] = '0;
				recent[k] = '0;
				older[k] = '0;
			end
			sample_cnt = 0;
			first_key = 6'd0;
			key_count = 7'd64;
			block_len = 13'd1024;
			fail_count = 0;
			tones_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_KEY: first_key = cfg_data[5:0];
					CFG_KEY_COUNT: key_count = cfg_data[6:0];
					CFG_BLOCK_LEN: block_len = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == ACT_COEFF)
					coef_tab[s_tdata[5:0]] = s_tdata[24:6];
				else
					take_sample(s_tdata[40:25]);
			end
			if (m_tvalid && m_tready) begin
				if (tones_due.size() == 0) begin
					report("unexpected word key", m_tdata[5:0], 0);
				end else begin
					tn = tones_due.pop_front();
					if (m_tdata[5:0] !== tn.key)
						report("result_key", m_tdata[5:0], tn.key);
					if (m_tdata[37:6] !== tn.mag)
						report("magnitude", m_tdata[37:6], tn.mag);
					if (m_tlast !== tn.last)
						report("last_of_block", m_tlast, tn.last);
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_goertzel_filter_bank_core.sv =====
// ----------------------------------------------------------------------------
// tb_goertzel_filter_bank_core
// drives coefficient and sample words and register writes into the filter
// bank with random gaps and result stalls; the checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_goertzel_filter_bank_core;
	import gfb_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_idx_t    cfg_index;
	logic [12:0] cfg_data;
	int          fail_count;
	int          pending;
	int          cycles = 0;
	int          n_items = 0;
	int          hold = 0;
	bit          calm = 1'b0;

	goertzel_filter_bank_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	goertzel_filter_bank_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (hold > 0) begin
			m_tready <= 1'b0;
			hold--;
		end else begin
			m_tready <= 1'b1;
			if (!calm && $urandom_range(0, 4) == 0)
				hold = gap();
		end
	end

	task automatic push_word(input logic act, input logic [5:0] key, input logic [18:0] cf,
			input logic [15:0] smp);
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat (gap()) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {7'd0, smp, cf, key};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		n_items++;
	endtask

	task automatic load_coef(input logic [5:0] key, input logic [18:0] cf);
		push_word(ACT_COEFF, key, cf, 16'($urandom));
	endtask

	task automatic feed(input logic [15:0] smp);
		push_word(ACT_SAMPLE, 6'($urandom), 19'($urandom), smp);
	endtask

	// bank drained, then room for a sample still rotating the key ring
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
	endtask

	task automatic set_reg(input cfg_idx_t idx, input logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_bank(input logic [12:0] fk, input logic [12:0] kc,
			input logic [12:0] bl);
		settle();
		set_reg(CFG_FIRST_KEY, fk);
		set_reg(CFG_KEY_COUNT, kc);
		set_reg(CFG_BLOCK_LEN, bl);
	endtask

	function automatic logic [18:0] rand_coef();
		if ($urandom_range(0, 1))
			return 19'($urandom);
		return 19'($urandom_range(0, 262144) - 131072);
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int fk, kc, bl, len;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIRST_KEY;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every key gets a coefficient before any sample
		set_reg(CFG_BLOCK_LEN, 13'd0);
		load_coef(6'd0, 19'h40000);
		load_coef(6'd63, 19'h3FFFF);
		load_coef(6'd1, 19'd0);
		load_coef(6'd2, 19'd131072);
		load_coef(6'd3, 19'h60000);
		for (int k = 4; k < 63; k++)
			load_coef(k[5:0], rand_coef());
		feed(16'h7FFF);
		feed(16'h8000);

		// range past the table end
		set_bank(13'd63, 13'd127, 13'd3);
		feed(16'h0000);
		feed(16'h7FFF);
		feed(16'h8000);

		// empty range, and an index past the register list
		set_bank(13'd10, 13'd0, 13'd2);
		set_reg(2'd3, 13'h1FFF);
		feed(16'h1234);
		feed(16'hFEDC);

		// shortened block
		set_bank(13'd60, 13'd4, 13'd10);
		repeat (5) feed(rand_sample());
		settle();
		set_reg(CFG_BLOCK_LEN, 13'd3);
		feed(16'h7FFF);

		// length above the maximum on one key, then cut short
		set_bank(13'd0, 13'd1, 13'h1FFF);
		calm = 1'b1;
		repeat (20) feed(rand_sample());
		calm = 1'b0;
		settle();
		set_reg(CFG_BLOCK_LEN, 13'd8);
		feed(rand_sample());

		while (n_items < 460) begin
			case ($urandom_range(0, 7))
				0: kc = 64;
				1: kc = 0;
				2: kc = $urandom_range(65, 127);
				default: kc = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 5))
				0: fk = 0;
				1: fk = 63;
				default: fk = $urandom_range(0, 63);
			endcase
			case ($urandom_range(0, 5))
				0: bl = 0;
				1: bl = $urandom_range(7, 40);
				default: bl = $urandom_range(1, 6);
			endcase
			if (kc >= 32 && bl > 6)
				bl = $urandom_range(1, 6);
			set_bank(fk[12:0], kc[12:0], bl[12:0]);
			calm = ($urandom_range(0, 3) == 0);
			len = $urandom_range(20, 40);
			repeat (len) begin
				if ($urandom_range(0, 3) == 0)
					load_coef(6'($urandom), rand_coef());
				else
					feed(rand_sample());
			end
			calm = 1'b0;
			if (n_items >= 430)
				break;
		end

		settle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
